/* rtl/damped_3x3_ldlt_solver_core_defines.svh */
// assertion macros for the damped 3x3 ldlt solver
`ifndef DAMPED_3X3_LDLT_SOLVER_CORE_DEFINES_SVH
`define DAMPED_3X3_LDLT_SOLVER_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define LDLT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ldlt check failed");

// antecedent implies a delayed consequent
`define LDLT_ASSERT_DLY(lbl, ante, n, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
        else $error("ldlt latency check failed");

`endif

/* rtl/ldlt_pkg.sv */
// types, constants and arithmetic helpers for the ldlt solver
`default_nettype none
package ldlt_pkg;

    localparam int WORD_BITS  = 48;
    localparam int FRAC_BITS  = 24;
    localparam int FLOOR_BITS = 47;
    localparam int HALF_BITS  = WORD_BITS / 2;
    localparam int DIV_BITS   = WORD_BITS;
    localparam int DIV_LAT    = DIV_BITS + 2;
    localparam int MUL_LAT    = 2;

    localparam int I_PREP = 1;
    localparam int I_M1   = I_PREP + DIV_LAT + 1;
    localparam int I_SUB1 = I_M1 + MUL_LAT + 1;
    localparam int I_M2   = I_SUB1 + DIV_LAT + 1;
    localparam int I_SUB2 = I_M2 + MUL_LAT + 1;
    localparam int I_M3   = I_SUB2 + DIV_LAT + 1;
    localparam int I_X1   = I_M3 + MUL_LAT + 1;
    localparam int I_S    = I_X1 + MUL_LAT + 1;
    localparam int I_X0   = I_S + 1;
    localparam int LAST   = I_X0;
    localparam int LATENCY = LAST + 2;

    localparam int N_DIV = 6;
    localparam int N_MUL = 10;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [WORD_BITS-1:0] mag_t;
    typedef logic [FLOOR_BITS-1:0] floor_t;

    localparam word_t W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SINGULAR  = 2'd1,
        ST_SATURATED = 2'd2
    } status_t;

    typedef struct packed {
        word_t v;
        logic  s;
    } res_t;

    typedef struct packed {
        word_t m00;
        word_t m01;
        word_t m02;
        word_t m11;
        word_t m12;
        word_t m22;
        word_t dmp;
        word_t b0;
        word_t b1;
        word_t b2;
        word_t d0;
        word_t d1;
        word_t d2;
        word_t l01;
        word_t l02;
        word_t l12;
        word_t e12;
        word_t e22;
        word_t y0;
        word_t y1;
        word_t x0;
        word_t x1;
        word_t x2;
        word_t mx;
        logic  sat;
        logic  bad;
    } sys_t;

    function automatic mag_t mag(input word_t a);
        return a[WORD_BITS-1] ? mag_t'(-a) : mag_t'(a);
    endfunction

    function automatic res_t sadd(input word_t a, input word_t b);
        logic signed [WORD_BITS:0] t;
        res_t r;
        t = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        r.v = t[WORD_BITS-1:0];
        r.s = (t[WORD_BITS] != t[WORD_BITS-1]);
        if (r.s)
        begin
            r.v = t[WORD_BITS] ? W_MIN : W_MAX;
        end
        return r;
    endfunction

    function automatic res_t ssub(input word_t a, input word_t b);
        logic signed [WORD_BITS:0] t;
        res_t r;
        t = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        r.v = t[WORD_BITS-1:0];
        r.s = (t[WORD_BITS] != t[WORD_BITS-1]);
        if (r.s)
        begin
            r.v = t[WORD_BITS] ? W_MIN : W_MAX;
        end
        return r;
    endfunction

    // sign and magnitude back to a saturated word
    function automatic res_t pack(input logic neg, input logic ovf, input mag_t lo);
        res_t r;
        if (neg)
        begin
            r.s = ovf | (lo[WORD_BITS-1] & (|lo[WORD_BITS-2:0]));
            r.v = r.s ? W_MIN : word_t'(-lo);
        end
        else
        begin
            r.s = ovf | lo[WORD_BITS-1];
            r.v = r.s ? W_MAX : word_t'(lo);
        end
        return r;
    endfunction

    function automatic logic pivot_bad(input word_t p, input floor_t fl);
        mag_t m;
        m = mag(p);
        return (m == '0) || (m < mag_t'(fl));
    endfunction

endpackage
`default_nettype wire

/* rtl/ldlt_mul.sv */
// pipelined saturating fixed-point multiplier, split into half-word products
`default_nettype none
module ldlt_mul (
    input  logic           clk,
    input  ldlt_pkg::word_t a,
    input  ldlt_pkg::word_t b,
    output ldlt_pkg::word_t p,
    output logic           sat
);
    localparam int W = ldlt_pkg::WORD_BITS;
    localparam int H = ldlt_pkg::HALF_BITS;
    localparam int F = ldlt_pkg::FRAC_BITS;

    logic              neg_reg;
    logic [2*H-1:0]    ll_reg, lh_reg, hl_reg, hh_reg;
    ldlt_pkg::word_t   p_reg;
    logic              sat_reg;
    ldlt_pkg::mag_t    x, y;
    logic [2*W-1:0]    prod;
    ldlt_pkg::res_t    res_next;

    always_comb
    begin
        x = ldlt_pkg::mag(a);
        y = ldlt_pkg::mag(b);
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= a[W-1] ^ b[W-1];
        ll_reg  <= x[H-1:0] * y[H-1:0];
        lh_reg  <= x[H-1:0] * y[W-1:H];
        hl_reg  <= x[W-1:H] * y[H-1:0];
        hh_reg  <= x[W-1:H] * y[W-1:H];
    end

    always_comb
    begin
        prod = (2*W)'(ll_reg) + ((2*W)'(lh_reg) << H) + ((2*W)'(hl_reg) << H)
             + ((2*W)'(hh_reg) << (2*H));
        res_next = ldlt_pkg::pack(neg_reg, |prod[2*W-1:W+F], prod[W+F-1:F]);
    end

    always_ff @(posedge clk)
    begin
        p_reg   <= res_next.v;
        sat_reg <= res_next.s;
    end

    assign p   = p_reg;
    assign sat = sat_reg;
endmodule
`default_nettype wire

/* rtl/ldlt_div.sv */
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module ldlt_div (
    input  logic           clk,
    input  ldlt_pkg::word_t a,
    input  ldlt_pkg::word_t b,
    output ldlt_pkg::word_t q,
    output logic           sat
);
    localparam int W = ldlt_pkg::WORD_BITS;
    localparam int F = ldlt_pkg::FRAC_BITS;
    localparam int N = ldlt_pkg::DIV_BITS;

    logic           neg_reg [0:N];
    logic           ovf_reg [0:N];
    ldlt_pkg::mag_t d_reg   [0:N];
    ldlt_pkg::mag_t r_reg   [0:N];
    ldlt_pkg::mag_t nb_reg  [0:N];
    ldlt_pkg::mag_t q_reg   [0:N];
    logic           neg_next [0:N];
    logic           ovf_next [0:N];
    ldlt_pkg::mag_t d_next   [0:N];
    ldlt_pkg::mag_t r_next   [0:N];
    ldlt_pkg::mag_t nb_next  [0:N];
    ldlt_pkg::mag_t q_next   [0:N];
    ldlt_pkg::word_t out_reg;
    logic            sat_reg;
    ldlt_pkg::res_t  res_next;

    always_comb
    begin
        ldlt_pkg::mag_t n;
        logic [W:0]     t;
        logic           ge;
        n = ldlt_pkg::mag(a);
        neg_next[0] = a[W-1] ^ b[W-1];
        d_next[0]   = ldlt_pkg::mag(b);
        r_next[0]   = n >> (W - F);
        ovf_next[0] = (r_next[0] >= d_next[0]);
        nb_next[0]  = n << F;
        q_next[0]   = '0;
        for (int k = 1; k <= N; k++)
        begin
            t  = {r_reg[k-1], nb_reg[k-1][W-1]};
            ge = (t >= {1'b0, d_reg[k-1]});
            r_next[k]   = ge ? ldlt_pkg::mag_t'(t - {1'b0, d_reg[k-1]}) : t[W-1:0];
            q_next[k]   = {q_reg[k-1][W-2:0], ge};
            nb_next[k]  = nb_reg[k-1] << 1;
            d_next[k]   = d_reg[k-1];
            neg_next[k] = neg_reg[k-1];
            ovf_next[k] = ovf_reg[k-1];
        end
        res_next = ldlt_pkg::pack(neg_reg[N], ovf_reg[N], q_reg[N]);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= N; k++)
        begin
            neg_reg[k] <= neg_next[k];
            ovf_reg[k] <= ovf_next[k];
            d_reg[k]   <= d_next[k];
            r_reg[k]   <= r_next[k];
            nb_reg[k]  <= nb_next[k];
            q_reg[k]   <= q_next[k];
        end
        out_reg <= res_next.v;
        sat_reg <= res_next.s;
    end

    assign q   = out_reg;
    assign sat = sat_reg;
endmodule
`default_nettype wire

/* rtl/damped_3x3_ldlt_solver_core.sv */
// top level of the damped 3x3 ldlt solver pipeline
// A word may be started in every cycle and busy is always low. Each result
// appears on the step and status ports with done high for one cycle; the
// receiver cannot stall. The latency is set by three chained pivot divisions
// (one quotient bit per stage), plus four two-stage multiplier passes and the
// add/subtract stages.
`default_nettype none
`include "damped_3x3_ldlt_solver_core_defines.svh"
module damped_3x3_ldlt_solver_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 cfg_we,
    input  logic [46:0]          cfg_wdata,
    input  logic signed [47:0]   mat_00,
    input  logic signed [47:0]   mat_01,
    input  logic signed [47:0]   mat_02,
    input  logic signed [47:0]   mat_11,
    input  logic signed [47:0]   mat_12,
    input  logic signed [47:0]   mat_22,
    input  logic signed [47:0]   grad_0,
    input  logic signed [47:0]   grad_1,
    input  logic signed [47:0]   grad_2,
    input  logic [46:0]          damping,
    output logic                 done,
    output logic signed [47:0]   step_x,
    output logic signed [47:0]   step_y,
    output logic signed [47:0]   step_theta,
    output logic [1:0]           status
);
    localparam int LAST = ldlt_pkg::LAST;
    localparam int ND   = ldlt_pkg::N_DIV;
    localparam int NM   = ldlt_pkg::N_MUL;

    ldlt_pkg::floor_t floor_reg;
    ldlt_pkg::sys_t   pipe_reg  [0:LAST];
    ldlt_pkg::sys_t   pipe_next [0:LAST];
    logic             vld_reg   [0:LAST];
    logic             done_reg;
    ldlt_pkg::word_t  sx_reg, sy_reg, st_reg;
    ldlt_pkg::status_t status_reg;

    ldlt_pkg::word_t div_a [ND], div_b [ND], div_q [ND];
    logic            div_s [ND];
    ldlt_pkg::word_t mul_a [NM], mul_b [NM], mul_p [NM];
    logic            mul_s [NM];

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= ldlt_pkg::floor_t'(1);
        end
        else if (cfg_we)
        begin
            floor_reg <= cfg_wdata;
        end
    end

    for (genvar i = 0; i < ND; i++)
    begin : g_div
        ldlt_div u_div (.clk(clk), .a(div_a[i]), .b(div_b[i]), .q(div_q[i]), .sat(div_s[i]));
    end

    for (genvar i = 0; i < NM; i++)
    begin : g_mul
        ldlt_mul u_mul (.clk(clk), .a(mul_a[i]), .b(mul_b[i]), .p(mul_p[i]), .sat(mul_s[i]));
    end

    always_comb
    begin
        div_a[0] = pipe_reg[ldlt_pkg::I_PREP].m01; div_b[0] = pipe_reg[ldlt_pkg::I_PREP].d0;
        div_a[1] = pipe_reg[ldlt_pkg::I_PREP].m02; div_b[1] = pipe_reg[ldlt_pkg::I_PREP].d0;
        div_a[2] = pipe_reg[ldlt_pkg::I_PREP].b0;  div_b[2] = pipe_reg[ldlt_pkg::I_PREP].d0;
        div_a[3] = pipe_reg[ldlt_pkg::I_SUB1].e12; div_b[3] = pipe_reg[ldlt_pkg::I_SUB1].d1;
        div_a[4] = pipe_reg[ldlt_pkg::I_SUB1].b1;  div_b[4] = pipe_reg[ldlt_pkg::I_SUB1].d1;
        div_a[5] = pipe_reg[ldlt_pkg::I_SUB2].b2;  div_b[5] = pipe_reg[ldlt_pkg::I_SUB2].d2;

        mul_a[0] = pipe_reg[ldlt_pkg::I_M1].l01; mul_b[0] = pipe_reg[ldlt_pkg::I_M1].m01;
        mul_a[1] = pipe_reg[ldlt_pkg::I_M1].l01; mul_b[1] = pipe_reg[ldlt_pkg::I_M1].m02;
        mul_a[2] = pipe_reg[ldlt_pkg::I_M1].l02; mul_b[2] = pipe_reg[ldlt_pkg::I_M1].m02;
        mul_a[3] = pipe_reg[ldlt_pkg::I_M1].l01; mul_b[3] = pipe_reg[ldlt_pkg::I_M1].b0;
        mul_a[4] = pipe_reg[ldlt_pkg::I_M1].l02; mul_b[4] = pipe_reg[ldlt_pkg::I_M1].b0;
        mul_a[5] = pipe_reg[ldlt_pkg::I_M2].l12; mul_b[5] = pipe_reg[ldlt_pkg::I_M2].e12;
        mul_a[6] = pipe_reg[ldlt_pkg::I_M2].l12; mul_b[6] = pipe_reg[ldlt_pkg::I_M2].b1;
        mul_a[7] = pipe_reg[ldlt_pkg::I_M3].l12; mul_b[7] = pipe_reg[ldlt_pkg::I_M3].x2;
        mul_a[8] = pipe_reg[ldlt_pkg::I_M3].l02; mul_b[8] = pipe_reg[ldlt_pkg::I_M3].x2;
        mul_a[9] = pipe_reg[ldlt_pkg::I_X1].l01; mul_b[9] = pipe_reg[ldlt_pkg::I_X1].x1;
    end

    always_comb
    begin
        ldlt_pkg::res_t r;
        ldlt_pkg::sys_t p;

        pipe_next[0]     = '0;
        pipe_next[0].m00 = mat_00;
        pipe_next[0].m01 = mat_01;
        pipe_next[0].m02 = mat_02;
        pipe_next[0].m11 = mat_11;
        pipe_next[0].m12 = mat_12;
        pipe_next[0].m22 = mat_22;
        pipe_next[0].b0  = grad_0;
        pipe_next[0].b1  = grad_1;
        pipe_next[0].b2  = grad_2;
        pipe_next[0].dmp = ldlt_pkg::word_t'({1'b0, damping});
        for (int k = 1; k <= LAST; k++)
        begin
            pipe_next[k] = pipe_reg[k-1];
        end

        // negate gradient, damp the diagonal, first pivot
        p = pipe_reg[ldlt_pkg::I_PREP-1];
        r = ldlt_pkg::ssub('0, p.b0);      p.b0 = r.v;  p.sat = p.sat | r.s;
        r = ldlt_pkg::ssub('0, p.b1);      p.b1 = r.v;  p.sat = p.sat | r.s;
        r = ldlt_pkg::ssub('0, p.b2);      p.b2 = r.v;  p.sat = p.sat | r.s;
        r = ldlt_pkg::sadd(p.m00, p.dmp);  p.d0 = r.v;  p.sat = p.sat | r.s;
        r = ldlt_pkg::sadd(p.m11, p.dmp);  p.m11 = r.v; p.sat = p.sat | r.s;
        r = ldlt_pkg::sadd(p.m22, p.dmp);  p.m22 = r.v; p.sat = p.sat | r.s;
        p.bad = ldlt_pkg::pivot_bad(p.d0, floor_reg);
        pipe_next[ldlt_pkg::I_PREP] = p;

        p = pipe_reg[ldlt_pkg::I_M1-1];
        p.l01 = div_q[0];
        p.l02 = div_q[1];
        p.y0  = div_q[2];
        p.sat = p.sat | div_s[0] | div_s[1] | div_s[2];
        pipe_next[ldlt_pkg::I_M1] = p;

        // row 0 update of rows 1 and 2
        p = pipe_reg[ldlt_pkg::I_SUB1-1];
        p.sat = p.sat | mul_s[0] | mul_s[1] | mul_s[2] | mul_s[3] | mul_s[4];
        r = ldlt_pkg::ssub(p.m11, mul_p[0]); p.d1  = r.v; p.sat = p.sat | r.s;
        r = ldlt_pkg::ssub(p.m12, mul_p[1]); p.e12 = r.v; p.sat = p.sat | r.s;
        r = ldlt_pkg::ssub(p.m22, mul_p[2]); p.e22 = r.v; p.sat = p.sat | r.s;
        r = ldlt_pkg::ssub(p.b1,  mul_p[3]); p.b1  = r.v; p.sat = p.sat | r.s;
        r = ldlt_pkg::ssub(p.b2,  mul_p[4]); p.b2  = r.v; p.sat = p.sat | r.s;
        p.bad = p.bad | ldlt_pkg::pivot_bad(p.d1, floor_reg);
        pipe_next[ldlt_pkg::I_SUB1] = p;

        p = pipe_reg[ldlt_pkg::I_M2-1];
        p.l12 = div_q[3];
        p.y1  = div_q[4];
        p.sat = p.sat | div_s[3] | div_s[4];
        pipe_next[ldlt_pkg::I_M2] = p;

        // row 1 update of row 2
        p = pipe_reg[ldlt_pkg::I_SUB2-1];
        p.sat = p.sat | mul_s[5] | mul_s[6];
        r = ldlt_pkg::ssub(p.e22, mul_p[5]); p.d2 = r.v; p.sat = p.sat | r.s;
        r = ldlt_pkg::ssub(p.b2,  mul_p[6]); p.b2 = r.v; p.sat = p.sat | r.s;
        p.bad = p.bad | ldlt_pkg::pivot_bad(p.d2, floor_reg);
        pipe_next[ldlt_pkg::I_SUB2] = p;

        p = pipe_reg[ldlt_pkg::I_M3-1];
        p.x2  = div_q[5];
        p.sat = p.sat | div_s[5];
        pipe_next[ldlt_pkg::I_M3] = p;

        // back substitution
        p = pipe_reg[ldlt_pkg::I_X1-1];
        p.sat = p.sat | mul_s[7] | mul_s[8];
        r = ldlt_pkg::ssub(p.y1, mul_p[7]); p.x1 = r.v; p.sat = p.sat | r.s;
        p.mx = mul_p[8];
        pipe_next[ldlt_pkg::I_X1] = p;

        p = pipe_reg[ldlt_pkg::I_S-1];
        p.sat = p.sat | mul_s[9];
        r = ldlt_pkg::sadd(mul_p[9], p.mx); p.mx = r.v; p.sat = p.sat | r.s;
        pipe_next[ldlt_pkg::I_S] = p;

        p = pipe_reg[ldlt_pkg::I_X0-1];
        r = ldlt_pkg::ssub(p.y0, p.mx); p.x0 = r.v; p.sat = p.sat | r.s;
        pipe_next[ldlt_pkg::I_X0] = p;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= LAST; k++)
        begin
            pipe_reg[k] <= pipe_next[k];
        end
        if (pipe_reg[LAST].bad)
        begin
            sx_reg     <= '0;
            sy_reg     <= '0;
            st_reg     <= '0;
            status_reg <= ldlt_pkg::ST_SINGULAR;
        end
        else
        begin
            sx_reg     <= pipe_reg[LAST].x0;
            sy_reg     <= pipe_reg[LAST].x1;
            st_reg     <= pipe_reg[LAST].x2;
            status_reg <= pipe_reg[LAST].sat ? ldlt_pkg::ST_SATURATED : ldlt_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LAST; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= start;
            for (int k = 1; k <= LAST; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            done_reg <= vld_reg[LAST];
        end
    end

    assign done       = done_reg;
    assign step_x     = sx_reg;
    assign step_y     = sy_reg;
    assign step_theta = st_reg;
    assign status     = status_reg;

    `LDLT_ASSERT_DLY(a_start_done, start && !busy, ldlt_pkg::LATENCY, done)
    `LDLT_ASSERT_IMP(a_done_start, done, $past(start, ldlt_pkg::LATENCY))
    `LDLT_ASSERT_IMP(a_singular_zero, done && status == ldlt_pkg::ST_SINGULAR,
        step_x == '0 && step_y == '0 && step_theta == '0)
endmodule
`default_nettype wire

/* sim/testbench.sv */
// self-checking testbench for the damped 3x3 ldlt solver core
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAT_CYCLES = 169;
    localparam int N_RANDOM   = 1200;
    localparam int WD_LIMIT   = 4000;

    typedef logic signed [47:0] fx_t;

    typedef struct packed {
        fx_t m00, m01, m02, m11, m12, m22, g0, g1, g2;
        logic [46:0] dmp;
    } system_t;

    typedef struct packed {
        fx_t sx, sy, st;
        ldlt_pkg::status_t code;
    } step_t;

    typedef struct packed {
        logic    chk;
        system_t sys;
        step_t   res;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic cfg_we = 1'b0;
    logic [46:0] cfg_wdata = '0;
    fx_t mat_00 = '0, mat_01 = '0, mat_02 = '0, mat_11 = '0, mat_12 = '0, mat_22 = '0;
    fx_t grad_0 = '0, grad_1 = '0, grad_2 = '0;
    logic [46:0] damping = '0;
    logic done;
    fx_t step_x, step_y, step_theta;
    logic [1:0] status;

    logic [46:0] floor_q = 47'd1;
    step_t pending_steps[$];
    int mismatches = 0;
    int idle_cycles = 0;

    damped_3x3_ldlt_solver_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .mat_00(mat_00), .mat_01(mat_01), .mat_02(mat_02),
        .mat_11(mat_11), .mat_12(mat_12), .mat_22(mat_22),
        .grad_0(grad_0), .grad_1(grad_1), .grad_2(grad_2),
        .damping(damping), .done(done), .step_x(step_x), .step_y(step_y),
        .step_theta(step_theta), .status(status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // saturating fixed-point arithmetic on 48-bit words
    function automatic fx_t sat_word(input logic signed [129:0] v, inout logic sat);
        if (v > 130'sh7FFFFFFFFFFF)
        begin
            sat = 1'b1;
            return 48'sh7FFFFFFFFFFF;
        end
        if (v < -130'sh800000000000)
        begin
            sat = 1'b1;
            return 48'sh800000000000;
        end
        return fx_t'(v);
    endfunction

    function automatic fx_t fx_add(input fx_t a, input fx_t b, inout logic sat);
        return sat_word(130'(a) + 130'(b), sat);
    endfunction

    function automatic fx_t fx_sub(input fx_t a, input fx_t b, inout logic sat);
        return sat_word(130'(a) - 130'(b), sat);
    endfunction

    function automatic fx_t fx_mul(input fx_t a, input fx_t b, inout logic sat);
        logic signed [129:0] p;
        p = 130'(a) * 130'(b);
        p = (p < 0) ? -((-p) >>> 24) : (p >>> 24);
        return sat_word(p, sat);
    endfunction

    function automatic fx_t fx_div(input fx_t a, input fx_t b, inout logic sat);
        logic signed [129:0] n, q;
        n = 130'(a) <<< 24;
        q = n / 130'(b);
        return sat_word(q, sat);
    endfunction

    function automatic logic weak_pivot(input fx_t p);
        logic [48:0] m;
        m = (p < 0) ? 49'(-50'(p)) : 49'(p);
        return (m == 0) || (m < 49'(floor_q));
    endfunction

    function automatic step_t solve_system(input system_t s);
        logic sat;
        fx_t b0, b1, b2, d0, d1, d2, l01, l02, l12, e12, e22, y0, y1, x0, x1, x2;
        step_t r;
        sat = 1'b0;
        r = '{sx: '0, sy: '0, st: '0, code: ldlt_pkg::ST_SINGULAR};
        b0 = fx_sub('0, s.g0, sat);
        b1 = fx_sub('0, s.g1, sat);
        b2 = fx_sub('0, s.g2, sat);
        d0 = fx_add(s.m00, fx_t'({1'b0, s.dmp}), sat);
        if (weak_pivot(d0))
            return r;
        l01 = fx_div(s.m01, d0, sat);
        l02 = fx_div(s.m02, d0, sat);
        d1 = fx_sub(fx_add(s.m11, fx_t'({1'b0, s.dmp}), sat), fx_mul(l01, s.m01, sat), sat);
        e12 = fx_sub(s.m12, fx_mul(l01, s.m02, sat), sat);
        e22 = fx_sub(fx_add(s.m22, fx_t'({1'b0, s.dmp}), sat), fx_mul(l02, s.m02, sat), sat);
        b1 = fx_sub(b1, fx_mul(l01, b0, sat), sat);
        b2 = fx_sub(b2, fx_mul(l02, b0, sat), sat);
        y0 = fx_div(b0, d0, sat);
        if (weak_pivot(d1))
            return r;
        l12 = fx_div(e12, d1, sat);
        d2 = fx_sub(e22, fx_mul(l12, e12, sat), sat);
        b2 = fx_sub(b2, fx_mul(l12, b1, sat), sat);
        y1 = fx_div(b1, d1, sat);
        if (weak_pivot(d2))
            return r;
        x2 = fx_div(b2, d2, sat);
        x1 = fx_sub(y1, fx_mul(l12, x2, sat), sat);
        x0 = fx_sub(y0, fx_add(fx_mul(l01, x1, sat), fx_mul(l02, x2, sat), sat), sat);
        r.sx = x0;
        r.sy = x1;
        r.st = x2;
        r.code = sat ? ldlt_pkg::ST_SATURATED : ldlt_pkg::ST_OK;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input fx_t got, input fx_t want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        step_t want;
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && done)
        begin
            if (pending_steps.size() == 0)
            begin
                report_mismatch("unexpected word", '0, '0);
            end
            else
            begin
                want = pending_steps.pop_front();
                if (step_x !== want.sx)
                    report_mismatch("step_x", step_x, want.sx);
                if (step_y !== want.sy)
                    report_mismatch("step_y", step_y, want.sy);
                if (step_theta !== want.st)
                    report_mismatch("step_theta", step_theta, want.st);
                if (status !== want.code)
                    report_mismatch("status", fx_t'(status), fx_t'(want.code));
            end
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic fx_t rand_fx(input int mode);
        case (mode)
            0: return fx_t'({$urandom, $urandom});
            1: return fx_t'($signed(25'($urandom)));
            2: return fx_t'($signed(32'($urandom)));
            default: return fx_t'($signed(20'($urandom)));
        endcase
    endfunction

    // random system: mostly narrow random entries, some wide noise
    function automatic system_t rand_system();
        system_t s;
        int mode;
        mode = $urandom_range(0, 9);
        if (mode == 0)
        begin
            s = system_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom});
            s.dmp = 47'({$urandom, $urandom});
            return s;
        end
        s.m01 = rand_fx(mode % 4);
        s.m02 = rand_fx(mode % 4);
        s.m12 = rand_fx(mode % 4);
        s.m00 = rand_fx(mode % 4);
        s.m11 = rand_fx(mode % 4);
        s.m22 = rand_fx(mode % 4);
        s.g0 = rand_fx($urandom_range(0, 3));
        s.g1 = rand_fx($urandom_range(0, 3));
        s.g2 = rand_fx($urandom_range(0, 3));
        s.dmp = ($urandom_range(0, 3) == 0) ? 47'({$urandom, $urandom}) : 47'($urandom);
        return s;
    endfunction

    task automatic write_floor(input logic [46:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        floor_q = v;
    endtask

    task automatic send_system(input system_t s, input step_t want, input logic chk);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        mat_00 <= s.m00; mat_01 <= s.m01; mat_02 <= s.m02;
        mat_11 <= s.m11; mat_12 <= s.m12; mat_22 <= s.m22;
        grad_0 <= s.g0; grad_1 <= s.g1; grad_2 <= s.g2;
        damping <= s.dmp;
        start <= 1'b1;
        pending_steps.push_back(chk ? want : solve_system(s));
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_steps.size() != 0)
            @(posedge clk);
        repeat (LAT_CYCLES + 10)
            @(posedge clk);
    endtask

    localparam fx_t ONE = 48'sd16777216;
    localparam fx_t PMAX = 48'sh7FFFFFFFFFFF;
    localparam fx_t NMAX = 48'sh800000000000;
    localparam step_t SING = '{sx: '0, sy: '0, st: '0, code: ldlt_pkg::ST_SINGULAR};

    row_t directed[] = '{
        '{1'b1, '{'0, '0, '0, '0, '0, '0, '0, '0, '0, '0}, SING},
        '{1'b1, '{ONE, '0, '0, ONE, '0, ONE, '0, '0, '0, '0},
            '{sx: '0, sy: '0, st: '0, code: ldlt_pkg::ST_OK}},
        '{1'b1, '{ONE, '0, '0, ONE, '0, ONE, ONE, -ONE, 2 * ONE, '0},
            '{sx: -ONE, sy: ONE, st: -2 * ONE, code: ldlt_pkg::ST_OK}},
        '{1'b1, '{ONE, '0, '0, '0, '0, ONE, '0, '0, '0, '0}, SING},
        '{1'b1, '{ONE, '0, '0, ONE, '0, '0, '0, '0, '0, '0}, SING},
        '{1'b0, '{'0, '0, '0, '0, '0, '0, ONE, ONE, ONE, 47'(ONE)}, SING},
        '{1'b0, '{PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX,
            47'h7FFFFFFFFFFF}, SING},
        '{1'b0, '{NMAX, NMAX, NMAX, NMAX, NMAX, NMAX, NMAX, NMAX, NMAX, '0}, SING},
        '{1'b0, '{48'sd1, '0, '0, 48'sd1, '0, 48'sd1, NMAX, NMAX, NMAX, '0}, SING},
        '{1'b0, '{-ONE, ONE / 2, -ONE / 4, -ONE, ONE / 8, -ONE, ONE, ONE, -ONE, '0},
            SING},
        '{1'b0, '{ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, '0}, SING},
        '{1'b0, '{4 * ONE, ONE, ONE, 4 * ONE, ONE, 4 * ONE, -ONE, 3 * ONE, ONE, 47'd5},
            SING},
        '{1'b0, '{48'sd1, PMAX, NMAX, 48'sd1, PMAX, 48'sd1, ONE, ONE, ONE, '0}, SING}
    };

    initial
    begin
        system_t s;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_system(directed[i].sys, directed[i].res, directed[i].chk);
        drain();
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: write_floor('0);
                1: write_floor(47'h7FFFFFFFFFFF);
                2: write_floor(47'd16777);
                default: write_floor(47'(ONE));
            endcase
            for (int n = 0; n < N_RANDOM / 4; n++)
            begin
                s = rand_system();
                send_system(s, SING, 1'b0);
                if (n == 40)
                    drain();
            end
            drain();
        end
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
